// ===== hw/rtl/suffix_array_lcp_builder_assert.svh =====
// Assertion macros for the RTL files; only salcp_seq.sv includes them.
`ifndef SUFFIX_ARRAY_LCP_BUILDER_ASSERT_SVH
`define SUFFIX_ARRAY_LCP_BUILDER_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define SALCP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define SALCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SALCP_ASSERT(lbl, clk, rst_n, prop, msg)
`define SALCP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/salcp_pkg.sv =====
package salcp_pkg;

  localparam int unsigned MAX_LEN   = 1024;
  localparam int unsigned ALPHABET  = 128;
  localparam int unsigned CHR_W     = 7;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned LCP_W     = 10;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned SLOTS     = MAX_LEN + 1;
  localparam int unsigned CNT_DEPTH = 2048;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic [POS_W-1:0] start_position;
    logic [LCP_W-1:0] lcp_previous;
    logic             error;
  } res_t;

endpackage

// ===== hw/rtl/salcp_ram.sv =====
module salcp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/salcp_seq.sv =====
`include "suffix_array_lcp_builder_assert.svh"

module salcp_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [salcp_pkg::CMD_W-1:0]  command_i,
  input  logic [salcp_pkg::CHR_W-1:0]  character_i,
  input  logic [salcp_pkg::POS_W-1:0]  rank_index_i,
  output logic                         busy_o,
  output logic                         done_o,
  output salcp_pkg::res_t              res_o
);
  import salcp_pkg::*;

  localparam int unsigned TXT_AW = $clog2(MAX_LEN);
  localparam int unsigned CNT_AW = $clog2(CNT_DEPTH);
  localparam int unsigned ST_W   = 6;

  localparam logic [ST_W-1:0] S_IDLE  = 6'd0;
  localparam logic [ST_W-1:0] S_RD    = 6'd1;
  localparam logic [ST_W-1:0] S_ICLR  = 6'd2;
  localparam logic [ST_W-1:0] S_IMRK0 = 6'd3;
  localparam logic [ST_W-1:0] S_IMRK1 = 6'd4;
  localparam logic [ST_W-1:0] S_SUM0  = 6'd5;
  localparam logic [ST_W-1:0] S_SUM1  = 6'd6;
  localparam logic [ST_W-1:0] S_IRNK0 = 6'd7;
  localparam logic [ST_W-1:0] S_IRNK1 = 6'd8;
  localparam logic [ST_W-1:0] S_IRNK2 = 6'd9;
  localparam logic [ST_W-1:0] S_ROUND = 6'd10;
  localparam logic [ST_W-1:0] S_KEY0  = 6'd11;
  localparam logic [ST_W-1:0] S_KEY1  = 6'd12;
  localparam logic [ST_W-1:0] S_CLR   = 6'd13;
  localparam logic [ST_W-1:0] S_CNT0  = 6'd14;
  localparam logic [ST_W-1:0] S_CNT1  = 6'd15;
  localparam logic [ST_W-1:0] S_CNT2  = 6'd16;
  localparam logic [ST_W-1:0] S_PL0   = 6'd17;
  localparam logic [ST_W-1:0] S_PL1   = 6'd18;
  localparam logic [ST_W-1:0] S_PL2   = 6'd19;
  localparam logic [ST_W-1:0] S_PL3   = 6'd20;
  localparam logic [ST_W-1:0] S_NR0   = 6'd21;
  localparam logic [ST_W-1:0] S_NR1   = 6'd22;
  localparam logic [ST_W-1:0] S_NR2   = 6'd23;
  localparam logic [ST_W-1:0] S_CPY0  = 6'd24;
  localparam logic [ST_W-1:0] S_CPY1  = 6'd25;
  localparam logic [ST_W-1:0] S_FIN0  = 6'd26;
  localparam logic [ST_W-1:0] S_FIN1  = 6'd27;
  localparam logic [ST_W-1:0] S_LCP0  = 6'd28;
  localparam logic [ST_W-1:0] S_LCP1  = 6'd29;
  localparam logic [ST_W-1:0] S_LCP2  = 6'd30;
  localparam logic [ST_W-1:0] S_LCP3  = 6'd31;
  localparam logic [ST_W-1:0] S_LCP4  = 6'd32;

  // control registers
  logic [ST_W-1:0]  state_q, state_d;
  logic [POS_W-1:0] len_q, len_d;
  logic             built_q, built_d;
  logic [POS_W-1:0] i_q, i_d;
  logic [POS_W:0]   k_q, k_d;
  logic [POS_W-1:0] classes_q, classes_d;
  logic [POS_W-1:0] acc_q, acc_d;
  logic [POS_W-1:0] lim_q, lim_d;
  logic             pass_q, pass_d;
  logic             init_q, init_d;
  // work registers
  logic [POS_W-1:0] v_q, v_d;
  logic [POS_W-1:0] e_q, e_d;
  logic [POS_W-1:0] cls_q, cls_d;
  logic [POS_W-1:0] pr_q, pr_d;
  logic [POS_W-1:0] pk_q, pk_d;
  logic [POS_W-1:0] r_q, r_d;
  logic [POS_W-1:0] j_q, j_d;
  logic [LCP_W-1:0] h_q, h_d;

  // memory ports
  logic              txt_we;
  logic [TXT_AW-1:0] txt_waddr, txta_raddr, txtb_raddr;
  logic [CHR_W-1:0]  txt_wdata, txta_rd, txtb_rd;
  logic              sa_we, rank_we, key_we, scr_we, lcp_we, cnt_we;
  logic [POS_W-1:0]  sa_waddr, rank_waddr, key_waddr, scr_waddr, lcp_waddr;
  logic [POS_W-1:0]  sa_raddr, rank_raddr, key_raddr, scr_raddr, lcp_raddr;
  logic [POS_W-1:0]  sa_wdata, rank_wdata, key_wdata, scr_wdata;
  logic [POS_W-1:0]  sa_rd, rank_rd, key_rd, scr_rd;
  logic [LCP_W-1:0]  lcp_wdata, lcp_rd;
  logic [CNT_AW-1:0] cnt_waddr, cnt_raddr;
  logic [POS_W-1:0]  cnt_wdata, cnt_rd;

  // shared combinational helpers
  logic             last_up;
  logic [POS_W-1:0] m_val;
  logic [POS_W:0]   ik_sum;
  logic [POS_W:0]   ih_sum, jh_sum;
  logic [CHR_W-1:0] chr_cur;
  logic [POS_W-1:0] sel_key;
  logic [POS_W-1:0] acc_sum;
  logic [POS_W-1:0] cls_nxt;
  logic             lcp_more;

  assign last_up  = (i_q == len_q);
  assign m_val    = len_q + POS_W'(1);
  assign ik_sum   = {1'b0, i_q} + k_q;
  assign ih_sum   = {1'b0, i_q} + (POS_W + 1)'(h_q);
  assign jh_sum   = {1'b0, j_q} + (POS_W + 1)'(h_q);
  assign chr_cur  = last_up ? CHR_W'(0) : txta_rd;
  assign sel_key  = pass_q ? rank_rd : key_rd;
  assign acc_sum  = acc_q + cnt_rd;
  assign cls_nxt  = ((i_q != '0) && ((rank_rd != pr_q) || (key_rd != pk_q)))
                    ? cls_q + POS_W'(1) : cls_q;
  assign lcp_more = (ih_sum < {1'b0, len_q}) && (jh_sum < {1'b0, len_q});

  // sequencer
  always_comb begin
    state_d = state_q;   len_d = len_q;     built_d = built_q;
    i_d = i_q;           k_d = k_q;         classes_d = classes_q;
    acc_d = acc_q;       lim_d = lim_q;     pass_d = pass_q;
    init_d = init_q;     v_d = v_q;         e_d = e_q;
    cls_d = cls_q;       pr_d = pr_q;       pk_d = pk_q;
    r_d = r_q;           j_d = j_q;         h_d = h_q;

    txt_we = 1'b0;  txt_waddr = len_q[TXT_AW-1:0];  txt_wdata = character_i;
    txta_raddr = i_q[TXT_AW-1:0];  txtb_raddr = '0;
    sa_we = 1'b0;   sa_waddr = '0;   sa_wdata = '0;   sa_raddr = i_q;
    rank_we = 1'b0; rank_waddr = i_q; rank_wdata = '0; rank_raddr = i_q;
    key_we = 1'b0;  key_waddr = i_q;  key_wdata = '0;  key_raddr = i_q;
    scr_we = 1'b0;  scr_waddr = '0;   scr_wdata = '0;  scr_raddr = i_q;
    lcp_we = 1'b0;  lcp_waddr = r_q;  lcp_wdata = h_q; lcp_raddr = i_q;
    cnt_we = 1'b0;  cnt_waddr = i_q;  cnt_wdata = '0;  cnt_raddr = i_q;

    done_o = 1'b0;
    res_o  = '0;

    case (state_q)
      S_IDLE: begin
        sa_raddr  = rank_index_i;
        lcp_raddr = rank_index_i;
        if (start_i) begin
          case (command_i)
            CMD_APPEND: begin
              done_o = 1'b1;
              if ((len_q < POS_W'(MAX_LEN)) && (character_i != '0)) begin
                txt_we  = 1'b1;
                len_d   = len_q + POS_W'(1);
                built_d = 1'b0;
              end else begin
                res_o.error = 1'b1;
              end
            end
            CMD_BUILD: begin
              built_d = 1'b0;
              i_d     = '0;
              state_d = S_ICLR;
            end
            CMD_READ: begin
              if (built_q && (rank_index_i <= len_q)) begin
                state_d = S_RD;
              end else begin
                done_o      = 1'b1;
                res_o.error = 1'b1;
              end
            end
            default: begin
              done_o      = 1'b1;
              res_o.error = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        done_o               = 1'b1;
        res_o.start_position = sa_rd;
        res_o.lcp_previous   = lcp_rd;
        state_d              = S_IDLE;
      end
      // initial ranks from single characters
      S_ICLR: begin
        cnt_we = 1'b1;
        if (i_q == POS_W'(ALPHABET - 1)) begin
          i_d = '0;  state_d = S_IMRK0;
        end else begin
          i_d = i_q + POS_W'(1);
        end
      end
      S_IMRK0: state_d = S_IMRK1;
      S_IMRK1: begin
        cnt_we    = 1'b1;
        cnt_waddr = CNT_AW'(chr_cur);
        cnt_wdata = POS_W'(1);
        if (last_up) begin
          i_d = '0;  acc_d = '0;  lim_d = POS_W'(ALPHABET - 1);
          init_d = 1'b1;  state_d = S_SUM0;
        end else begin
          i_d = i_q + POS_W'(1);  state_d = S_IMRK0;
        end
      end
      // running prefix sum over the counts
      S_SUM0: state_d = S_SUM1;
      S_SUM1: begin
        cnt_we    = 1'b1;
        cnt_wdata = acc_sum;
        acc_d     = acc_sum;
        if (i_q == lim_q) begin
          if (init_q) begin
            classes_d = acc_sum;  i_d = '0;  state_d = S_IRNK0;
          end else begin
            i_d = len_q;  state_d = S_PL0;
          end
        end else begin
          i_d = i_q + POS_W'(1);  state_d = S_SUM0;
        end
      end
      S_IRNK0: state_d = S_IRNK1;
      S_IRNK1: begin
        cnt_raddr = CNT_AW'(chr_cur);
        state_d   = S_IRNK2;
      end
      S_IRNK2: begin
        rank_we    = 1'b1;
        rank_wdata = cnt_rd - POS_W'(1);
        if (last_up) begin
          init_d = 1'b0;  k_d = (POS_W + 1)'(1);  state_d = S_ROUND;
        end else begin
          i_d = i_q + POS_W'(1);  state_d = S_IRNK0;
        end
      end
      // one doubling round
      S_ROUND: begin
        i_d = '0;
        state_d = (classes_q >= m_val) ? S_FIN0 : S_KEY0;
      end
      S_KEY0: begin
        rank_raddr = ik_sum[POS_W-1:0];
        if (ik_sum <= {1'b0, len_q}) begin
          state_d = S_KEY1;
        end else begin
          key_we = 1'b1;
          if (last_up) begin
            i_d = '0;  pass_d = 1'b0;  state_d = S_CLR;
          end else begin
            i_d = i_q + POS_W'(1);
          end
        end
      end
      S_KEY1: begin
        key_we    = 1'b1;
        key_wdata = rank_rd + POS_W'(1);
        if (last_up) begin
          i_d = '0;  pass_d = 1'b0;  state_d = S_CLR;
        end else begin
          i_d = i_q + POS_W'(1);  state_d = S_KEY0;
        end
      end
      S_CLR: begin
        cnt_we = 1'b1;
        if (i_q == classes_q) begin
          i_d = '0;  state_d = S_CNT0;
        end else begin
          i_d = i_q + POS_W'(1);
        end
      end
      // histogram of the sort key
      S_CNT0: state_d = S_CNT1;
      S_CNT1: begin
        cnt_raddr = sel_key;
        v_d       = sel_key;
        state_d   = S_CNT2;
      end
      S_CNT2: begin
        cnt_we    = 1'b1;
        cnt_waddr = v_q;
        cnt_wdata = cnt_rd + POS_W'(1);
        if (last_up) begin
          i_d = '0;  acc_d = '0;  lim_d = classes_q;  state_d = S_SUM0;
        end else begin
          i_d = i_q + POS_W'(1);  state_d = S_CNT0;
        end
      end
      // stable placement, walking down
      S_PL0: begin
        if (pass_q) begin
          state_d = S_PL1;
        end else begin
          e_d = i_q;  state_d = S_PL2;
        end
      end
      S_PL1: begin
        e_d        = scr_rd;
        rank_raddr = scr_rd;
        state_d    = S_PL2;
      end
      S_PL2: begin
        cnt_raddr = sel_key;
        v_d       = sel_key;
        state_d   = S_PL3;
      end
      S_PL3: begin
        cnt_we    = 1'b1;
        cnt_waddr = v_q;
        cnt_wdata = cnt_rd - POS_W'(1);
        if (pass_q) begin
          sa_we = 1'b1;  sa_waddr = cnt_rd - POS_W'(1);  sa_wdata = e_q;
        end else begin
          scr_we = 1'b1;  scr_waddr = cnt_rd - POS_W'(1);  scr_wdata = e_q;
        end
        if (i_q == '0) begin
          if (pass_q) begin
            cls_d = '0;  state_d = S_NR0;
          end else begin
            pass_d = 1'b1;  state_d = S_CLR;
          end
        end else begin
          i_d = i_q - POS_W'(1);  state_d = S_PL0;
        end
      end
      // dense ranks for the new order
      S_NR0: state_d = S_NR1;
      S_NR1: begin
        e_d        = sa_rd;
        rank_raddr = sa_rd;
        key_raddr  = sa_rd;
        state_d    = S_NR2;
      end
      S_NR2: begin
        scr_we    = 1'b1;
        scr_waddr = e_q;
        scr_wdata = cls_nxt;
        cls_d     = cls_nxt;
        pr_d      = rank_rd;
        pk_d      = key_rd;
        if (last_up) begin
          classes_d = cls_nxt + POS_W'(1);  i_d = '0;  state_d = S_CPY0;
        end else begin
          i_d = i_q + POS_W'(1);  state_d = S_NR0;
        end
      end
      S_CPY0: state_d = S_CPY1;
      S_CPY1: begin
        rank_we    = 1'b1;
        rank_wdata = scr_rd;
        if (last_up) begin
          k_d = {k_q[POS_W-1:0], 1'b0};  state_d = S_ROUND;
        end else begin
          i_d = i_q + POS_W'(1);  state_d = S_CPY0;
        end
      end
      // invert ranks into the suffix order
      S_FIN0: state_d = S_FIN1;
      S_FIN1: begin
        sa_we    = 1'b1;
        sa_waddr = rank_rd;
        sa_wdata = i_q;
        if (last_up) begin
          i_d = '0;  h_d = '0;  state_d = S_LCP0;
        end else begin
          i_d = i_q + POS_W'(1);  state_d = S_FIN0;
        end
      end
      // LCP by text position, carrying h down by one
      S_LCP0: state_d = S_LCP1;
      S_LCP1: begin
        r_d      = rank_rd;
        sa_raddr = rank_rd - POS_W'(1);
        if (rank_rd == '0) begin
          lcp_we    = 1'b1;
          lcp_waddr = '0;
          lcp_wdata = '0;
          h_d       = '0;
          if (last_up) begin
            built_d = 1'b1;  done_o = 1'b1;  state_d = S_IDLE;
          end else begin
            i_d = i_q + POS_W'(1);  state_d = S_LCP0;
          end
        end else begin
          state_d = S_LCP2;
        end
      end
      S_LCP2: begin
        j_d     = sa_rd;
        state_d = S_LCP3;
      end
      S_LCP3: begin
        txta_raddr = ih_sum[TXT_AW-1:0];
        txtb_raddr = jh_sum[TXT_AW-1:0];
        if (lcp_more) begin
          state_d = S_LCP4;
        end else begin
          lcp_we = 1'b1;
          h_d    = (h_q != '0) ? h_q - LCP_W'(1) : h_q;
          if (last_up) begin
            built_d = 1'b1;  done_o = 1'b1;  state_d = S_IDLE;
          end else begin
            i_d = i_q + POS_W'(1);  state_d = S_LCP0;
          end
        end
      end
      S_LCP4: begin
        if (txta_rd == txtb_rd) begin
          h_d = h_q + LCP_W'(1);  state_d = S_LCP3;
        end else begin
          lcp_we = 1'b1;
          h_d    = (h_q != '0) ? h_q - LCP_W'(1) : h_q;
          if (last_up) begin
            built_d = 1'b1;  done_o = 1'b1;  state_d = S_IDLE;
          end else begin
            i_d = i_q + POS_W'(1);  state_d = S_LCP0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      built_q <= 1'b0;
      pass_q  <= 1'b0;
      init_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      built_q <= built_d;
      pass_q  <= pass_d;
      init_q  <= init_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;  k_q <= k_d;  classes_q <= classes_d;  acc_q <= acc_d;
    lim_q <= lim_d;  v_q <= v_d;  e_q <= e_d;  cls_q <= cls_d;
    pr_q <= pr_d;  pk_q <= pk_d;  r_q <= r_d;  j_q <= j_d;  h_q <= h_d;
  end

  assign busy_o = (state_q != S_IDLE);

  // text held twice so LCP compares read both suffixes at once
  salcp_ram #(.Width(CHR_W), .Depth(MAX_LEN)) u_txta (
    .clk_i, .we_i(txt_we), .waddr_i(txt_waddr), .wdata_i(txt_wdata),
    .raddr_i(txta_raddr), .rdata_o(txta_rd));
  salcp_ram #(.Width(CHR_W), .Depth(MAX_LEN)) u_txtb (
    .clk_i, .we_i(txt_we), .waddr_i(txt_waddr), .wdata_i(txt_wdata),
    .raddr_i(txtb_raddr), .rdata_o(txtb_rd));
  salcp_ram #(.Width(POS_W), .Depth(SLOTS)) u_sa (
    .clk_i, .we_i(sa_we), .waddr_i(sa_waddr), .wdata_i(sa_wdata),
    .raddr_i(sa_raddr), .rdata_o(sa_rd));
  salcp_ram #(.Width(POS_W), .Depth(SLOTS)) u_rank (
    .clk_i, .we_i(rank_we), .waddr_i(rank_waddr), .wdata_i(rank_wdata),
    .raddr_i(rank_raddr), .rdata_o(rank_rd));
  salcp_ram #(.Width(POS_W), .Depth(SLOTS)) u_key (
    .clk_i, .we_i(key_we), .waddr_i(key_waddr), .wdata_i(key_wdata),
    .raddr_i(key_raddr), .rdata_o(key_rd));
  salcp_ram #(.Width(POS_W), .Depth(SLOTS)) u_scr (
    .clk_i, .we_i(scr_we), .waddr_i(scr_waddr), .wdata_i(scr_wdata),
    .raddr_i(scr_raddr), .rdata_o(scr_rd));
  salcp_ram #(.Width(LCP_W), .Depth(SLOTS)) u_lcp (
    .clk_i, .we_i(lcp_we), .waddr_i(lcp_waddr), .wdata_i(lcp_wdata),
    .raddr_i(lcp_raddr), .rdata_o(lcp_rd));
  salcp_ram #(.Width(POS_W), .Depth(CNT_DEPTH)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rd));

  `SALCP_ASSERT(a_len_bound, clk_i, rst_ni, len_q <= POS_W'(MAX_LEN), "text length overflow")
  `SALCP_ASSERT(a_rd_built, clk_i, rst_ni, (state_q == S_RD) |-> built_q, "read without build")
  `SALCP_ASSERT(a_done_src, clk_i, rst_ni, done_o |-> (start_i || busy_o), "spurious result")

endmodule

// ===== hw/rtl/suffix_array_lcp_builder.sv =====
// Suffix array and LCP builder.
// Input channel: in_valid_i / in_stall_o carry one request: command_i
// (append, build, read), character_i for appends, rank_index_i for reads.
// Output channel: out_valid_o / out_stall_i carry exactly one result per
// request: start_position_o, lcp_previous_o and error_o.
// Timing: an append, an invalid command or a rejected read answers in the
// cycle after acceptance; a good read passes through the read state first.
// A build runs on one sequencer sharing the store ports over m = n + 1
// suffix slots: the initial ranks, at most log2(n)+1 doubling rounds, the
// inversion and the LCP walk, in that order.
// While the sequencer runs, in_stall_o is high.
// Reset clears the text length and the built flag; the stores hold garbage
// until written, and no clearing pass is needed.
// A stalled result holds in the output register; a new request is taken only
// once that register is free or being emptied in the same cycle.
module suffix_array_lcp_builder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [salcp_pkg::CMD_W-1:0]  command_i,
  input  logic [salcp_pkg::CHR_W-1:0]  character_i,
  input  logic [salcp_pkg::POS_W-1:0]  rank_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [salcp_pkg::POS_W-1:0]  start_position_o,
  output logic [salcp_pkg::LCP_W-1:0]  lcp_previous_o,
  output logic                         error_o
);
  import salcp_pkg::*;

  logic  busy, done, accept;
  res_t  res;
  logic  out_valid_q, out_valid_d;
  res_t  out_res_q;

  assign in_stall_o = busy | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;

  salcp_seq u_seq (
    .clk_i,
    .rst_ni,
    .start_i      (accept),
    .command_i,
    .character_i,
    .rank_index_i,
    .busy_o       (busy),
    .done_o       (done),
    .res_o        (res)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign start_position_o = out_res_q.start_position;
  assign lcp_previous_o   = out_res_q.lcp_previous;
  assign error_o          = out_res_q.error;

endmodule
